// ===== rtl/mxi_pkg.sv =====
// shared constants for the 3x3 matrix inverse core
`timescale 1ns / 1ps
`default_nettype none
package mxi_pkg;

  localparam int IN_WIDTH_DEF     = 16;
  localparam int OUT_WIDTH_DEF    = 32;
  localparam int FRAC_SHIFT       = 24;
  localparam int MID_QUEUE_DEPTH  = 4;
  localparam int OUT_QUEUE_DEPTH  = 2;
  localparam int NUM_ELEM         = 9;

  // cofactor c = a[i0]*a[i1] - a[i2]*a[i3]
  localparam int COF_IDX [NUM_ELEM][4] = '{
    '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
    '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
    '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
  };

  function automatic int cof_width(input int iw);
    return (2 * iw + 1 > 64) ? 64 : 2 * iw + 1;
  endfunction

  function automatic int det_width(input int iw);
    return (3 * iw + 3 > 64) ? 64 : 3 * iw + 3;
  endfunction

  function automatic int num_width(input int iw);
    return (cof_width(iw) + FRAC_SHIFT > 64) ? 64 : cof_width(iw) + FRAC_SHIFT;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/three_by_three_matrix_inverse_core.sv =====
// top level of the 3x3 matrix inverse core
//
//  channel   direction  handshake          word
//  in_       input      push / full        nine Q8.8 elements m00..m22
//  out_      output     empty / pop        nine Q16.16 elements r00..r22, singular
//
// one matrix per cycle sustained as long as neither queue fills; a matrix passes the
// front pipeline, the middle queue and the back pipeline, whose depth is set by the
// one-bit-per-stage divide pipelines
// reset clears pipeline valids and both queues; no clearing pass
// the front stalls only when the middle queue is full, the back only when
// the result queue is full
`timescale 1ns / 1ps
`default_nettype none
module three_by_three_matrix_inverse_core #(
  parameter int IN_WIDTH  = mxi_pkg::IN_WIDTH_DEF,
  parameter int OUT_WIDTH = mxi_pkg::OUT_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic signed [IN_WIDTH-1:0]  in_m00,
  input  wire logic signed [IN_WIDTH-1:0]  in_m01,
  input  wire logic signed [IN_WIDTH-1:0]  in_m02,
  input  wire logic signed [IN_WIDTH-1:0]  in_m10,
  input  wire logic signed [IN_WIDTH-1:0]  in_m11,
  input  wire logic signed [IN_WIDTH-1:0]  in_m12,
  input  wire logic signed [IN_WIDTH-1:0]  in_m20,
  input  wire logic signed [IN_WIDTH-1:0]  in_m21,
  input  wire logic signed [IN_WIDTH-1:0]  in_m22,
  output logic                             empty,
  input  wire logic                        pop,
  output logic signed [OUT_WIDTH-1:0]      out_r00,
  output logic signed [OUT_WIDTH-1:0]      out_r01,
  output logic signed [OUT_WIDTH-1:0]      out_r02,
  output logic signed [OUT_WIDTH-1:0]      out_r10,
  output logic signed [OUT_WIDTH-1:0]      out_r11,
  output logic signed [OUT_WIDTH-1:0]      out_r12,
  output logic signed [OUT_WIDTH-1:0]      out_r20,
  output logic signed [OUT_WIDTH-1:0]      out_r21,
  output logic signed [OUT_WIDTH-1:0]      out_r22,
  output logic                             out_singular
);
  localparam int NE = mxi_pkg::NUM_ELEM;
  localparam int MW = NE * mxi_pkg::cof_width(IN_WIDTH) + mxi_pkg::det_width(IN_WIDTH) + 1;
  localparam int RW = NE * OUT_WIDTH + 1;
  localparam int OW = OUT_WIDTH;

  logic [NE*IN_WIDTH-1:0] m_flat;
  logic [MW-1:0]          mid_din, mid_dout;
  logic                   mid_push, mid_pop, mid_full, mid_empty;
  logic [RW-1:0]          res_din, res_dout;
  logic                   res_push, res_full;

  assign m_flat = {in_m22, in_m21, in_m20, in_m12, in_m11, in_m10, in_m02, in_m01, in_m00};

  mxi_front #(
    .IN_WIDTH (IN_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push && !full),
    .m_flat (m_flat),
    .full   (full),
    .q_full (mid_full),
    .q_push (mid_push),
    .q_data (mid_din)
  );

  mxi_fifo #(
    .WIDTH (MW),
    .DEPTH (mxi_pkg::MID_QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .din   (mid_din),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .full  (mid_full),
    .empty (mid_empty)
  );

  mxi_back #(
    .IN_WIDTH  (IN_WIDTH),
    .OUT_WIDTH (OUT_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (mid_empty),
    .q_data  (mid_dout),
    .q_pop   (mid_pop),
    .o_full  (res_full),
    .o_push  (res_push),
    .o_data  (res_din)
  );

  mxi_fifo #(
    .WIDTH (RW),
    .DEPTH (mxi_pkg::OUT_QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_din),
    .pop   (pop && !empty),
    .dout  (res_dout),
    .full  (res_full),
    .empty (empty)
  );

  assign out_r00      = res_dout[0*OW +: OW];
  assign out_r01      = res_dout[1*OW +: OW];
  assign out_r02      = res_dout[2*OW +: OW];
  assign out_r10      = res_dout[3*OW +: OW];
  assign out_r11      = res_dout[4*OW +: OW];
  assign out_r12      = res_dout[5*OW +: OW];
  assign out_r20      = res_dout[6*OW +: OW];
  assign out_r21      = res_dout[7*OW +: OW];
  assign out_r22      = res_dout[8*OW +: OW];
  assign out_singular = res_dout[NE*OW];

`ifndef SYNTHESIS
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_singular) |-> (out_r00 == '0 && out_r11 == '0 && out_r22 == '0
                                  && out_r01 == '0 && out_r12 == '0 && out_r20 == '0))
    else $error("singular word carries nonzero elements");
`endif
endmodule
`default_nettype wire

// ===== rtl/mxi_fifo.sv =====
// small register queue with show-ahead read
`timescale 1ns / 1ps
`default_nettype none
module mxi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  full,
  output logic                  empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;

  assign dout  = mem_r[rd_ptr_r];
  assign full  = (count_r == CNTW'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> (!full || pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(DEPTH))
    else $error("queue count out of range");
`endif
endmodule
`default_nettype wire

// ===== rtl/mxi_front.sv =====
// front pipeline: cofactors, determinant and singular check
`timescale 1ns / 1ps
`default_nettype none
module mxi_front #(
  parameter int IN_WIDTH = mxi_pkg::IN_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                push,
  input  wire logic [mxi_pkg::NUM_ELEM*IN_WIDTH-1:0] m_flat,
  output logic                                     full,
  input  wire logic                                q_full,
  output logic                                     q_push,
  output logic [mxi_pkg::NUM_ELEM*mxi_pkg::cof_width(IN_WIDTH)
                + mxi_pkg::det_width(IN_WIDTH):0]  q_data
);
  localparam int NE = mxi_pkg::NUM_ELEM;
  localparam int IW = IN_WIDTH;
  localparam int CW = mxi_pkg::cof_width(IW);
  localparam int DW = mxi_pkg::det_width(IW);
  localparam int STAGES = 5;

  logic [STAGES-1:0] v_r;
  logic              adv;

  logic signed [IW-1:0]   a1_r [NE];
  logic signed [2*IW-1:0] p2_r [2*NE];
  logic signed [IW-1:0]   a2_r [3];
  logic signed [CW-1:0]   c3_r [NE];
  logic signed [IW-1:0]   a3_r [3];
  logic signed [DW-1:0]   dp4_r [3];
  logic signed [CW-1:0]   c4_r [NE];
  logic signed [DW-1:0]   det5_r;
  logic                   sing5_r;
  logic signed [CW-1:0]   c5_r [NE];
  logic signed [DW-1:0]   det_sum;

  assign adv    = !v_r[STAGES-1] || !q_full;
  assign full   = !adv;
  assign q_push = v_r[STAGES-1] && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[STAGES-2:0], push};
    end
  end

  assign det_sum = dp4_r[0] + dp4_r[1] + dp4_r[2];

  genvar g;
  generate
    for (g = 0; g < NE; g++) begin : g_elem
      always_ff @(posedge clk) begin
        if (adv) begin
          a1_r[g] <= m_flat[g*IW +: IW];
          p2_r[2*g]   <= a1_r[mxi_pkg::COF_IDX[g][0]] * a1_r[mxi_pkg::COF_IDX[g][1]];
          p2_r[2*g+1] <= a1_r[mxi_pkg::COF_IDX[g][2]] * a1_r[mxi_pkg::COF_IDX[g][3]];
          c3_r[g] <= CW'(p2_r[2*g]) - CW'(p2_r[2*g+1]);
          c4_r[g] <= c3_r[g];
          c5_r[g] <= c4_r[g];
        end
      end
      assign q_data[g*CW +: CW] = c5_r[g];
    end
    for (g = 0; g < 3; g++) begin : g_row0
      logic signed [IW+CW-1:0] prod;
      assign prod = a3_r[g] * c3_r[g];
      always_ff @(posedge clk) begin
        if (adv) begin
          a2_r[g]  <= a1_r[g];
          a3_r[g]  <= a2_r[g];
          dp4_r[g] <= DW'(prod);
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv) begin
      det5_r  <= det_sum;
      sing5_r <= (det_sum == '0);
    end
  end

  assign q_data[NE*CW +: DW] = det5_r;
  assign q_data[NE*CW+DW]    = sing5_r;
endmodule
`default_nettype wire

// ===== rtl/mxi_div.sv =====
// one pipelined divide lane: rounded, saturated cofactor / determinant
`timescale 1ns / 1ps
`default_nettype none
module mxi_div #(
  parameter int IN_WIDTH  = mxi_pkg::IN_WIDTH_DEF,
  parameter int OUT_WIDTH = mxi_pkg::OUT_WIDTH_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       adv,
  input  wire logic signed [mxi_pkg::cof_width(IN_WIDTH)-1:0] cof,
  input  wire logic signed [mxi_pkg::det_width(IN_WIDTH)-1:0] det,
  output logic [OUT_WIDTH-1:0]                            res
);
  localparam int CW = mxi_pkg::cof_width(IN_WIDTH);
  localparam int DW = mxi_pkg::det_width(IN_WIDTH);
  localparam int NW = mxi_pkg::num_width(IN_WIDTH);
  localparam int SH = mxi_pkg::FRAC_SHIFT;
  localparam int OW = OUT_WIDTH;
  localparam int QW = NW + 1;
  localparam int CMPW = (QW > OW) ? QW : OW;

  logic [DW-1:0] rem_r [NW+1];
  logic [NW-1:0] num_r [NW+1];
  logic [NW-1:0] quo_r [NW+1];
  logic [DW-1:0] d_r   [NW+1];
  logic          neg_r [NW+1];

  logic [CW-1:0]   cof_mag;
  logic [DW-1:0]   det_mag;
  logic            round_up;
  logic [CMPW-1:0] q1, smax, lim, qs;
  logic [OW-1:0]   res_nxt;

  assign cof_mag = cof[CW-1] ? CW'(0) - cof : cof;
  assign det_mag = det[DW-1] ? DW'(0) - det : det;

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= '0;
      num_r[0] <= NW'({cof_mag, {SH{1'b0}}});
      quo_r[0] <= '0;
      d_r[0]   <= det_mag;
      neg_r[0] <= cof[CW-1] ^ det[DW-1];
    end
  end

  genvar i;
  generate
    for (i = 0; i < NW; i++) begin : g_step
      logic [DW:0] trial;
      logic        ge;
      assign trial = {rem_r[i], num_r[i][NW-1]};
      assign ge    = (trial >= {1'b0, d_r[i]});
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[i+1] <= ge ? DW'(trial - {1'b0, d_r[i]}) : DW'(trial);
          num_r[i+1] <= {num_r[i][NW-2:0], 1'b0};
          quo_r[i+1] <= {quo_r[i][NW-2:0], ge};
          d_r[i+1]   <= d_r[i];
          neg_r[i+1] <= neg_r[i];
        end
      end
    end
  endgenerate

  // round half away from zero, then clamp
  assign round_up = ({rem_r[NW], 1'b0} >= {1'b0, d_r[NW]});
  assign q1   = CMPW'(quo_r[NW]) + CMPW'(round_up);
  assign smax = {{(CMPW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  assign lim  = smax + CMPW'(1);

  always_comb begin
    if (neg_r[NW]) begin
      qs      = (q1 > lim) ? lim : q1;
      res_nxt = OW'(CMPW'(0) - qs);
    end else begin
      qs      = (q1 > smax) ? smax : q1;
      res_nxt = OW'(qs);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/mxi_back.sv =====
// back pipeline: nine divide lanes and result packing
`timescale 1ns / 1ps
`default_nettype none
module mxi_back #(
  parameter int IN_WIDTH  = mxi_pkg::IN_WIDTH_DEF,
  parameter int OUT_WIDTH = mxi_pkg::OUT_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 q_empty,
  input  wire logic [mxi_pkg::NUM_ELEM*mxi_pkg::cof_width(IN_WIDTH)
                     + mxi_pkg::det_width(IN_WIDTH):0] q_data,
  output logic                                      q_pop,
  input  wire logic                                 o_full,
  output logic                                      o_push,
  output logic [mxi_pkg::NUM_ELEM*OUT_WIDTH:0]      o_data
);
  localparam int NE  = mxi_pkg::NUM_ELEM;
  localparam int CW  = mxi_pkg::cof_width(IN_WIDTH);
  localparam int DW  = mxi_pkg::det_width(IN_WIDTH);
  localparam int NW  = mxi_pkg::num_width(IN_WIDTH);
  localparam int OW  = OUT_WIDTH;
  localparam int LAT = NW + 2;

  logic [LAT-1:0] v_r;
  logic [LAT-1:0] sing_r;
  logic           adv;

  assign adv    = !v_r[LAT-1] || !o_full;
  assign q_pop  = adv && !q_empty;
  assign o_push = v_r[LAT-1] && !o_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAT-2:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sing_r <= {sing_r[LAT-2:0], q_data[NE*CW+DW]};
    end
  end

  genvar r, c;
  generate
    for (r = 0; r < 3; r++) begin : g_row
      for (c = 0; c < 3; c++) begin : g_col
        logic [OW-1:0] res;
        // inverse[r][c] uses the transposed cofactor
        mxi_div #(
          .IN_WIDTH  (IN_WIDTH),
          .OUT_WIDTH (OUT_WIDTH)
        ) u_div (
          .clk (clk),
          .adv (adv),
          .cof (q_data[(3*c+r)*CW +: CW]),
          .det (q_data[NE*CW +: DW]),
          .res (res)
        );
        assign o_data[(3*r+c)*OW +: OW] = sing_r[LAT-1] ? '0 : res;
      end
    end
  endgenerate

  assign o_data[NE*OW] = sing_r[LAT-1];
endmodule
`default_nettype wire
